/* design/xdds_pkg.sv */
// Shared types, constants and the generator step for the xorshift decimal digit source.
// Used by xdds_ctrl, xdds_dp and xorshift_decimal_digit_source; depends on nothing.
package xdds_pkg;

    // Generator and formatting constants.
    localparam logic [63:0] SEED_RESET  = 64'd14;
    localparam logic [5:0]  BUDGET_MAX  = 6'd55;
    localparam logic [5:0]  ASCII_ZERO  = 6'd48;
    localparam int          MAX_DIGITS  = 10;

    // Reciprocal of ten: q = (x * RECIP_TEN) >> RECIP_SHIFT is exact for 32-bit x.
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;   // latch the budget of an accepted request
        logic advance;    // step the generator, load the low word
        logic div;        // register the quotient of the word by ten
        logic store;      // store the remainder digit, word becomes quotient
        logic emit;       // move the top stored digit to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_skip;   // request yields nothing: zero budget or zero state
        logic word_zero;  // current word has no digits left
        logic count_full; // digit store is full
        logic count_zero; // digit store is empty
        logic count_one;  // one digit left in the store
        logic run_done;   // the next character reaches the budget
        logic out_free;   // output register can take a character
    } t_status;

    // One xorshift step with shifts 13 left, 7 right, 17 left.
    function automatic logic [63:0] xs_advance(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        return b ^ (b << 17);
    endfunction

endpackage

/* design/xdds_ctrl.sv */
// Controller state machine for the xorshift decimal digit source.
// Depends on xdds_pkg for the command and status structs.
module xdds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output xdds_pkg::t_cmd   o_cmd,
    input  xdds_pkg::t_status i_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } t_ctrl_state;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        w_accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_req = 1'b1;
                    if (!i_status.req_skip) begin
                        n_state = ST_ADV;
                    end
                end
            end
            ST_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = ST_DIV;
            end
            ST_DIV: begin
                // A number ends when its word runs out; a zero word gives no digits.
                if (i_status.word_zero || i_status.count_full) begin
                    n_state = i_status.count_zero ? ST_ADV : ST_EMIT;
                end else begin
                    o_cmd.div = 1'b1;
                    n_state   = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = ST_DIV;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.count_one) begin
                        n_state = i_status.run_done ? ST_IDLE : ST_ADV;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/xdds_dp.sv */
// Datapath of the xorshift decimal digit source: generator, divide-by-ten, digit store, output.
// Depends on xdds_pkg for constants, the generator step and the command and status structs.
module xdds_dp #(
    parameter int MAX_DIGITS = xdds_pkg::MAX_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [63:0]       i_cfg_data,
    input  logic [5:0]        i_budget,
    input  xdds_pkg::t_cmd    i_cmd,
    output xdds_pkg::t_status o_status,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [5:0]        o_out_char,
    output logic              o_out_last
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = $clog2(MAX_DIGITS);

    logic [63:0] r_rng;
    logic [31:0] r_word;
    logic [31:0] r_quot;
    logic [3:0]  r_store [MAX_DIGITS];
    logic [CW-1:0] r_count;
    logic [5:0]  r_budget;
    logic [6:0]  r_sent;
    logic        r_out_valid;
    logic [5:0]  r_out_char;
    logic        r_out_last;

    logic [63:0] n_rng;
    logic [63:0] n_prod;
    logic [31:0] n_diff;
    logic [5:0]  n_budget;
    logic [CW-1:0] w_count_m1;
    logic [3:0]  w_top_digit;
    logic        w_last;

    // Generator step and divide-by-ten by reciprocal multiplication.
    assign n_rng   = xdds_pkg::xs_advance(r_rng);
    assign n_prod  = 64'(r_word) * 64'(xdds_pkg::RECIP_TEN);
    assign n_diff  = r_word - (r_quot << 3) - (r_quot << 1);

    // Budgets above range saturate.
    assign n_budget = (i_budget > xdds_pkg::BUDGET_MAX) ? xdds_pkg::BUDGET_MAX : i_budget;

    // Digits are read back most significant first from the top of the store.
    assign w_count_m1  = r_count - CW'(1);
    assign w_top_digit = r_store[w_count_m1[IW-1:0]];

    // Status toward the controller.
    always_comb begin
        o_status.req_skip   = (i_budget == 6'd0) || (r_rng == 64'd0);
        o_status.word_zero  = (r_word == 32'd0);
        o_status.count_full = (r_count == CW'(MAX_DIGITS));
        o_status.count_zero = (r_count == '0);
        o_status.count_one  = (r_count == CW'(1));
        o_status.run_done   = ((r_sent + 7'd1) >= {1'b0, r_budget});
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign w_last = o_status.count_one && o_status.run_done;

    // Control registers: generator state, counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng       <= xdds_pkg::SEED_RESET;
            r_count     <= '0;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rng <= i_cfg_data;
            end else if (i_cmd.advance) begin
                r_rng <= n_rng;
            end
            if (i_cmd.load_req) begin
                r_sent <= '0;
            end else if (i_cmd.emit) begin
                r_sent <= r_sent + 7'd1;
            end
            if (i_cmd.advance) begin
                r_count <= '0;
            end else if (i_cmd.store) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.emit) begin
                r_count <= w_count_m1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_budget <= n_budget;
        end
        if (i_cmd.advance) begin
            r_word <= n_rng[31:0];
        end else if (i_cmd.store) begin
            r_word <= r_quot;
        end
        if (i_cmd.div) begin
            r_quot <= {3'b000, n_prod[63:xdds_pkg::RECIP_SHIFT]};
        end
        if (i_cmd.store) begin
            r_store[r_count[IW-1:0]] <= n_diff[3:0];
        end
        if (i_cmd.emit) begin
            r_out_char <= xdds_pkg::ASCII_ZERO + {2'b00, w_top_digit};
            r_out_last <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

/* design/xorshift_decimal_digit_source.sv */
// Top level of the xorshift decimal digit source: controller plus datapath, stream ports.
// Depends on xdds_pkg, xdds_ctrl and xdds_dp.
//
// Each request on the slave stream carries a byte budget (budgets above 55 count as 55).
// The block steps a 64-bit xorshift generator (shifts 13, 7, 17), writes the low 32 bits
// of each new state as ASCII decimal digits, most significant first, and keeps going until
// at least the budget has been sent; a number is never split, and a zero word adds nothing.
// The final character carries tlast. A zero budget, or a generator state of zero, gives no
// characters. Writing the seed channel loads the generator; write it only while idle.
// One request is handled at a time. The idle state accepts a request; each number then
// takes one generator step, a multiply and a remainder step per digit in the shared
// divide-by-ten unit, one end check, and one emit step per character into the output
// register, which waits while the master side stalls.
module xorshift_decimal_digit_source #(
    parameter int MAX_DIGITS = xdds_pkg::MAX_DIGITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Seed write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [5:0] byte_budget, [7:6] zero
    // Character stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic        o_m_tlast
);

    xdds_pkg::t_cmd    w_cmd;
    xdds_pkg::t_status w_status;
    logic [5:0]        w_char;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    xdds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Generator, digit unit and output register.
    xdds_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_budget    (i_s_tdata[5:0]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_char  (w_char),
        .o_out_last  (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, w_char};

    // A character on the output is always a decimal digit.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata >= 8'd48 && o_m_tdata <= 8'd57))
        else $error("output character is not a decimal digit");

    // While idle, no digits are left in the store.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> w_status.count_zero)
        else $error("digit store not empty while idle");

    // Sending the final character returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_status.count_one && w_status.run_done) |=> o_s_tready)
        else $error("block not idle after final character");

    // A request that yields nothing leaves the block idle.
    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && w_status.req_skip) |=> o_s_tready)
        else $error("empty request did not return to idle");

endmodule
